@@ hdl/emagc_pkg.sv @@
package emagc_pkg;

  // Item modes carried on the input channel.
  localparam logic MODE_FRAME   = 1'b0;
  localparam logic MODE_UTT_END = 1'b1;

  // Reset value of the held estimate, 10.0 in Q7.8.
  localparam logic signed [15:0] START_RESET = 16'sd2560;

  // Saturation limits of a 16-bit Q7.8 result.
  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = 16'sh8000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input word into the item registers
    logic frame;     // frame item: peak tracking and normalisation
    logic accum;     // utterance end with a peak: fold peak into history
    logic idle_end;  // utterance end without a peak: clear peak only
    logic div_init;  // load the divider with the history sum
    logic div_step;  // one restoring division step
    logic fix;       // write back the average and decay the history
    logic load_out;  // move the finished result into the output register
  } emagc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_mode;
    logic peak_seen;
    logic div_last;
  } emagc_sts_t;

endpackage

@@ hdl/emagc_ctrl.sv @@
module emagc_ctrl
  import emagc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  emagc_sts_t sts,
  output emagc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.item_mode == MODE_FRAME) begin
          cmd.frame = 1'b1;
          state_nxt = ST_OUT;
        end else if (sts.peak_seen) begin
          cmd.accum = 1'b1;
          state_nxt = ST_DIV_INIT;
        end else begin
          cmd.idle_end = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // An accepted word keeps the input stalled while it is worked on.
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // The divider only runs for an utterance-end word.
  a_div_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (sts.item_mode == MODE_UTT_END))
    else $error("divider running for a frame word");

endmodule

@@ hdl/emagc_dp.sv @@
module emagc_dp
  import emagc_pkg::*;
#(
  parameter int HISTORY_LIMIT = 8
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  emagc_cmd_t         cmd,
  output emagc_sts_t         sts,
  input  logic               in_mode,
  input  logic signed [15:0] in_c0_value,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_start_estimate,
  output logic signed [15:0] out_normalized_c0,
  output logic signed [15:0] out_current_estimate
);

  localparam int SW     = 16 + $clog2(HISTORY_LIMIT);
  localparam int CW     = $clog2(HISTORY_LIMIT + 1);
  localparam int STEP_W = $clog2(SW);
  localparam logic [CW-1:0] CNT_LIMIT = CW'(HISTORY_LIMIT);
  localparam logic [CW-1:0] CNT_DECAY = CW'(HISTORY_LIMIT / 2);
  localparam logic signed [SW:0] Q_MAX = (SW + 1)'(32767);
  localparam logic signed [SW:0] Q_MIN = -(SW + 1)'(32768);

  // History and estimate state.
  logic signed [15:0]   held_r;
  logic signed [15:0]   peak_r;
  logic                 peak_seen_r;
  logic signed [SW-1:0] sum_r;
  logic [CW-1:0]        cnt_r;

  // Item, divider and result registers.
  logic                 mode_r;
  logic signed [15:0]   c0_r;
  logic [CW-1:0]        rem_r;
  logic [SW-1:0]        quo_r;
  logic [STEP_W-1:0]    step_r;
  logic                 neg_r;
  logic signed [15:0]   norm_r;
  logic signed [15:0]   out_norm_r;
  logic signed [15:0]   out_est_r;

  logic signed [16:0]   diff;
  logic signed [15:0]   diff_sat;
  logic [CW+1:0]        trial;
  logic [CW+1:0]        trial_sub;
  logic                 q_bit;
  logic signed [SW:0]   q_signed;
  logic signed [15:0]   q_sat;

  // Frame normalisation with saturation.
  always_comb begin
    diff = 17'(c0_r) - 17'(held_r);
    if (diff[16] != diff[15]) begin
      diff_sat = diff[16] ? SAT_MIN : SAT_MAX;
    end else begin
      diff_sat = diff[15:0];
    end
  end

  // One restoring step on the magnitude of the sum.
  always_comb begin
    trial     = {1'b0, rem_r, quo_r[SW-1]};
    trial_sub = trial - {2'b00, cnt_r};
    q_bit     = !trial_sub[CW+1];
  end

  // Signed quotient, truncated toward zero, clamped to 16 bits.
  always_comb begin
    q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (q_signed > Q_MAX) begin
      q_sat = SAT_MAX;
    end else if (q_signed < Q_MIN) begin
      q_sat = SAT_MIN;
    end else begin
      q_sat = q_signed[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= START_RESET;
      peak_r      <= '0;
      peak_seen_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        held_r <= cfg_start_estimate;
      end
      if (cmd.frame) begin
        if (!peak_seen_r || (c0_r > peak_r)) begin
          peak_r      <= c0_r;
          peak_seen_r <= 1'b1;
        end
      end
      if (cmd.accum) begin
        sum_r <= sum_r + SW'(peak_r);
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.accum || cmd.idle_end) begin
        peak_r      <= '0;
        peak_seen_r <= 1'b0;
      end
      if (cmd.fix) begin
        held_r <= q_sat;
        if (cnt_r >= CNT_LIMIT) begin
          sum_r <= sum_r >>> 1;
          cnt_r <= CNT_DECAY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      c0_r   <= in_c0_value;
    end
    if (cmd.frame) begin
      norm_r <= diff_sat;
    end
    if (cmd.accum || cmd.idle_end) begin
      norm_r <= '0;
    end
    if (cmd.div_init) begin
      neg_r  <= sum_r[SW-1];
      quo_r  <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
      rem_r  <= '0;
      step_r <= STEP_W'(SW - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= q_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
      quo_r  <= {quo_r[SW-2:0], q_bit};
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.load_out) begin
      out_norm_r <= norm_r;
      out_est_r  <= held_r;
    end
  end

  assign sts.item_mode        = mode_r;
  assign sts.peak_seen        = peak_seen_r;
  assign sts.div_last         = (step_r == '0);
  assign out_normalized_c0    = out_norm_r;
  assign out_current_estimate = out_est_r;

  // Between words the count stays below the limit.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (cnt_r < CNT_LIMIT))
    else $error("history count at or above the limit between words");

  // A frame always leaves a peak behind.
  a_frame_sets_peak: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame |=> peak_seen_r)
    else $error("peak flag not set after a frame");

  // Folding the peak into the history clears it.
  a_accum_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum |=> !peak_seen_r)
    else $error("peak flag still set after utterance end");

endmodule

@@ hdl/estimated_max_energy_agc.sv @@
// Frame word: captured, executed, then moved into the output register; the input stays
// stalled meanwhile. Utterance-end word with a peak: captured, folded into the history,
// divided by the restoring divider, which retires one quotient bit a cycle, written back
// and moved out. Utterance-end word without a peak: the same sequence as a frame word.
// Synchronous active-low reset: estimate 2560 (10.0), history and peak cleared, no word held.
module estimated_max_energy_agc
  import emagc_pkg::*;
#(
  parameter int HISTORY_LIMIT = 8
)
(
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_c0_value,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_normalized_c0,
  output logic signed [15:0] out_current_estimate,
  // Configuration channel: the start estimate register.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_start_estimate
);

  // The controller sequences each word through execute, the optional
  // division and the hand-over to the output register. The datapath holds
  // the estimate, the utterance peak, the history and the divider.
  emagc_cmd_t cmd;
  emagc_sts_t sts;

  // The start estimate is taken only while no word is in flight, and a
  // write loads the held estimate straight away.
  assign cfg_ready = !in_stall;

  emagc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The output register parts the two sides: once a result has moved into
  // it the next input word is taken, even while that result is stalled.
  emagc_dp #(
    .HISTORY_LIMIT (HISTORY_LIMIT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_mode              (in_mode),
    .in_c0_value          (in_c0_value),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_start_estimate   (cfg_start_estimate),
    .out_normalized_c0    (out_normalized_c0),
    .out_current_estimate (out_current_estimate)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import emagc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // History depth of the block under test. The predictor uses the same value.
  localparam int HISTORY_DEPTH = 8;

  // Fixed-point limits of a 16-bit Q7.8 value, as integers for the predictor.
  localparam int Q78_MAX = 32767;
  localparam int Q78_MIN = -32768;

  // Cycles to let pass once every expected word has arrived. The slowest word is an
  // utterance end with a peak, which runs through the divider.
  localparam int SETTLE_CYCLES = 40;

  // Chance, in percent, that either side idles in a given cycle.
  localparam int IDLE_PERCENT = 14;

  // One result word as the block should return it.
  typedef struct packed {
    logic signed [15:0] norm_c0;
    logic signed [15:0] estimate;
  } agc_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic signed [15:0] in_c0_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_normalized_c0;
  logic signed [15:0] out_current_estimate;
  logic               cfg_valid;
  logic               cfg_ready;
  logic signed [15:0] cfg_start_estimate;

  // Predictor state, kept at the widths the block uses.
  logic signed [15:0] held_estimate;
  logic signed [15:0] utterance_peak;
  logic               peak_seen;
  logic signed [18:0] history_sum;
  logic [3:0]         history_count;

  // Words predicted but not yet returned, oldest first.
  agc_word_t expected_words[$];
  agc_word_t oldest_word;

  // When set, neither side idles. A test sets hold_off to make the receiver
  // refuse words for that many cycles.
  bit steady;
  int hold_off;

  int fail_count;
  int frames_sent;
  int ends_sent;
  int peak_ends;
  int decays;
  int saturations;
  int estimate_writes;
  int words_checked;

  estimated_max_energy_agc #(
    .HISTORY_LIMIT(HISTORY_DEPTH)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_c0_value          (in_c0_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_normalized_c0    (out_normalized_c0),
    .out_current_estimate (out_current_estimate),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_start_estimate   (cfg_start_estimate)
  );

  // A 10 ns clock.
  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Every input is known from time zero; reset is held until the main
  // sequence releases it.
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_mode            = MODE_FRAME;
    in_c0_value        = '0;
    out_stall          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_start_estimate = '0;
    steady             = 1'b0;
    hold_off           = 0;
  end

  // Clamps a wide intermediate value to the 16-bit Q7.8 range.
  function automatic logic signed [15:0] clamp_q78(input int value);
    if (value > Q78_MAX) begin
      return 16'(Q78_MAX);
    end else if (value < Q78_MIN) begin
      return 16'(Q78_MIN);
    end
    return 16'(value);
  endfunction

  // Advances the predictor by one accepted word and queues the result the
  // block must return for it.
  task automatic apply_agc_word(input logic mode, input logic signed [15:0] c0);
    agc_word_t word;
    int        diff;
    int        average;
    word = '0;
    if (mode == MODE_FRAME) begin
      // The first frame of an utterance always sets the peak, however low it
      // is; later frames replace it only when strictly larger.
      if (!peak_seen || c0 > utterance_peak) begin
        utterance_peak = c0;
        peak_seen      = 1'b1;
      end
      diff = int'(c0) - int'(held_estimate);
      if (diff > Q78_MAX || diff < Q78_MIN) begin
        saturations++;
      end
      word.norm_c0 = clamp_q78(diff);
      frames_sent++;
    end else begin
      // An utterance with no frames leaves the history and the estimate alone.
      if (peak_seen) begin
        history_sum   = history_sum + utterance_peak;
        history_count = history_count + 4'd1;
        // The division truncates towards zero, as the block's divider does.
        average       = int'(history_sum) / int'(history_count);
        held_estimate = clamp_q78(average);
        if (int'(history_count) >= HISTORY_DEPTH) begin
          // Decay: the arithmetic shift rounds an odd negative sum downwards.
          history_sum   = history_sum >>> 1;
          history_count = 4'(HISTORY_DEPTH / 2);
          decays++;
        end
        peak_ends++;
      end
      utterance_peak = '0;
      peak_seen      = 1'b0;
      ends_sent++;
    end
    word.estimate = held_estimate;
    expected_words.push_back(word);
  endtask

  // Offers one word on the input channel and waits until the block takes it.
  // The word stays on the port afterwards until the next call or until the
  // channel is drained.
  task automatic send_word(input logic mode, input logic signed [15:0] c0);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_mode     = mode;
    in_c0_value = c0;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    apply_agc_word(mode, c0);
  endtask

  // Lowers the input valid and waits until every expected word has been
  // returned, then lets the block come to rest.
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the start estimate while the block is idle. The write also loads
  // the held estimate but leaves the history untouched.
  task automatic write_start_estimate(input logic signed [15:0] value);
    drain_block();
    @(negedge clk);
    cfg_valid          = 1'b1;
    cfg_start_estimate = value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    held_estimate = value;
    estimate_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Picks a c0 for a frame. Most values cluster round a level chosen for the
  // utterance, so that estimates wander over the whole range instead of
  // piling up near the top; some are fully random and some are extremes.
  function automatic logic signed [15:0] pick_c0(input int level);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'(Q78_MAX) : 16'(Q78_MIN);
      default: return clamp_q78(level + int'($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // The receiving side: random idling, long hold-offs on request.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall = 1'b1;
      hold_off  = hold_off - 1;
    end else begin
      out_stall = !steady && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Every word the block hands over is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: normalized_c0 %0d current_estimate %0d",
               out_normalized_c0, out_current_estimate);
        fail_count++;
      end else begin
        oldest_word = expected_words.pop_front();
        words_checked++;
        if (out_normalized_c0 !== oldest_word.norm_c0) begin
          $error("normalized_c0: expected %0d, actual %0d",
                 oldest_word.norm_c0, out_normalized_c0);
          fail_count++;
        end
        if (out_current_estimate !== oldest_word.estimate) begin
          $error("current_estimate: expected %0d, actual %0d",
                 oldest_word.estimate, out_current_estimate);
          fail_count++;
        end
      end
    end
  end

  // Straight after reset the history is empty. Eight single-frame utterances
  // fill it: seven peaks of -1 and one of -2 give a sum of -9 at the limit,
  // so the decay has to round the odd negative sum down to -5.
  task automatic test_history_decay();
    for (int utt = 0; utt < HISTORY_DEPTH; utt++) begin
      send_word(MODE_FRAME, (utt == HISTORY_DEPTH - 1) ? -16'sd2 : -16'sd1);
      send_word(MODE_UTT_END, 16'sd0);
    end
  endtask

  // Peak tracking and saturation. An utterance end with no frames must leave
  // the estimate as it is. In the next utterance the very first frame, the
  // most negative value, becomes the peak; a larger frame replaces it, while
  // an equal and a smaller one do not. Then the start estimate is pushed to
  // each end of the range so that frames at the opposite end saturate.
  task automatic test_peak_and_saturation();
    send_word(MODE_UTT_END, 16'sd0);
    send_word(MODE_FRAME, 16'(Q78_MIN));
    send_word(MODE_FRAME, 16'sd100);
    send_word(MODE_FRAME, 16'sd100);
    send_word(MODE_FRAME, -16'sd5);
    send_word(MODE_UTT_END, 16'sd0);
    write_start_estimate(16'(Q78_MIN));
    send_word(MODE_FRAME, 16'(Q78_MAX));
    write_start_estimate(16'(Q78_MAX));
    send_word(MODE_FRAME, 16'(Q78_MIN));
    send_word(MODE_FRAME, 16'sd0);
  endtask

  // The receiver refuses words for a long stretch while the sender keeps
  // offering frames, so the block must fill up and stall its input.
  task automatic test_backpressure();
    drain_block();
    hold_off = 300;
    for (int n = 0; n < 40; n++) begin
      send_word(MODE_FRAME, 16'($urandom));
    end
    send_word(MODE_UTT_END, 16'sd0);
  endtask

  // Random utterances in several phases, each started with a fresh start
  // estimate: both extremes, zero, the reset value and random values. Most
  // utterances are well formed, some are empty and a few run long. One phase
  // runs with no idling on either side.
  task automatic test_random_utterances();
    int sent;
    int level;
    int frames;
    int kind;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_start_estimate(16'(Q78_MIN));
        1: write_start_estimate(16'(Q78_MAX));
        2: write_start_estimate(16'sd0);
        3: write_start_estimate(START_RESET);
        default: write_start_estimate(16'($urandom));
      endcase
      steady = (phase == 2);
      sent   = 0;
      while (sent < 300) begin
        kind  = $urandom_range(99);
        level = int'($urandom_range(65535)) - 32768;
        if (kind < 80) begin
          frames = $urandom_range(1, 12);
        end else if (kind < 92) begin
          frames = 0;
        end else begin
          frames = $urandom_range(13, 40);
        end
        for (int f = 0; f < frames; f++) begin
          send_word(MODE_FRAME, pick_c0(level));
        end
        send_word(MODE_UTT_END, 16'($urandom));
        sent += frames + 1;
      end
      steady = 1'b0;
    end
  endtask

  // Main sequence: reset once, then each test in turn.
  initial begin
    fail_count      = 0;
    frames_sent     = 0;
    ends_sent       = 0;
    peak_ends       = 0;
    decays          = 0;
    saturations     = 0;
    estimate_writes = 0;
    words_checked   = 0;
    held_estimate   = START_RESET;
    utterance_peak  = '0;
    peak_seen       = 1'b0;
    history_sum     = '0;
    history_count   = '0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_history_decay();
    test_peak_and_saturation();
    test_backpressure();
    test_random_utterances();
    drain_block();

    $display("Covered %0d frame words and %0d utterance-end words, %0d of them with a peak.",
             frames_sent, ends_sent, peak_ends);
    $display("Compared %0d result words; %0d saturated frames, %0d decays, %0d estimate writes.",
             words_checked, saturations, decays, estimate_writes);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // A hung handshake ends the run here. A correct run needs well under a
  // tenth of this time.
  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
